[sv/qr_module_placement_walker_macros.svh]
// assertion macros for the qr module placement walker
`ifndef QR_MODULE_PLACEMENT_WALKER_MACROS_SVH
`define QR_MODULE_PLACEMENT_WALKER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define QMPW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define QMPW_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/qmpw_pkg.sv]
// shared types and constants of the qr module placement walker
package qmpw_pkg;

	// field widths
	localparam int VERSION_W   = 6;
	localparam int COORD_W     = 8;
	localparam int CENTRE_W    = 8;
	localparam int CFG_DATA_W  = 56;
	localparam int TDATA_W     = 24;
	localparam int BITS_PER_WORD = 8;
	localparam int ALIGN_SLOTS_DEF = 7;
	localparam int QUEUE_DEPTH = 2;

	// symbol geometry
	localparam logic [VERSION_W-1:0] VER_MIN     = 6'd1;
	localparam logic [VERSION_W-1:0] VER_MAX     = 6'd40;
	localparam logic [VERSION_W-1:0] VERINFO_MIN = 6'd7;
	localparam logic [COORD_W-1:0]   SIDE_BASE   = 8'd17;
	localparam logic [COORD_W-1:0]   TIMING_IDX  = 8'd6;
	localparam logic [COORD_W-1:0]   FINDER_SPAN = 8'd9;
	localparam logic [COORD_W-1:0]   FINDER_EDGE = 8'd8;
	localparam logic [COORD_W-1:0]   VERINFO_SPAN = 8'd11;
	localparam logic [COORD_W-1:0]   RESET_CORNER = 8'(4 * 1 + 17 - 1);
	localparam int ALIGN_RADIUS = 2;
	// x/7 for x up to 40 as (x*37)>>8
	localparam int DIV7_MUL = 37;

	// configuration register indexes
	typedef enum logic {
		CFG_VERSION = 1'b0,
		CFG_ALIGN   = 1'b1
	} cfg_idx_t;

	// operation codes
	typedef enum logic {
		OP_RESTART = 1'b0,
		OP_PLACE   = 1'b1
	} op_t;

	// one queued command
	typedef struct packed {
		op_t              op;
		logic [7:0]       data_byte;
	} item_t;

	// queue head seen by the walker
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

endpackage

[sv/qr_module_placement_walker.sv]
// top level of the qr data module placement walker
// Usage:
//  s_* stream takes commands: s_tuser is the op (0 restarts the walk at the
//  bottom-right corner, 1 places a byte), s_tdata the byte. A place command
//  yields eight words on m_*, most significant bit first; m_tlast marks the
//  eighth, m_tuser flags words past the end of the data area (row and column 0).
//  cfg_* writes version (index 0, restarts the walk) or the packed alignment
//  centres (index 1); write only while idle. cfg_ready is always high.
// Timing:
//  a command is popped in the idle state and its words are registered in
//  the emit state; each skipped function module adds a search step, the
//  walker stepping one module per cycle unless stalled. A two-entry
//  command queue lets new commands in while the walker or the output is busy.
// Reset:
//  version 1, no alignment centres, walk at the bottom-right corner.
//  When m_tready is low the output word holds and the walker waits on it;
//  commands keep queuing until the queue is full.
`include "qr_module_placement_walker_macros.svh"

module qr_module_placement_walker #(
	parameter int ALIGN_SLOTS = qmpw_pkg::ALIGN_SLOTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // data_byte
	input  logic                              s_tuser,   // op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [qmpw_pkg::TDATA_W-1:0]      m_tdata,   // row, column, bit_value
	output logic                              m_tlast,   // last
	output logic                              m_tuser,   // past_end
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [qmpw_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import qmpw_pkg::*;

	logic [VERSION_W-1:0]              version_q;
	logic [ALIGN_SLOTS*CENTRE_W-1:0]   centres_q;
	logic                              restart_q;
	queue_out_t                        q_out;
	logic                              pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VER_MIN;
			centres_q <= '0;
			restart_q <= 1'b0;
		end else begin
			restart_q <= cfg_valid && cfg_ready && (cfg_idx_t'(cfg_index) == CFG_VERSION);
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_VERSION: version_q <= cfg_data[VERSION_W-1:0];
					CFG_ALIGN:   centres_q <= cfg_data[ALIGN_SLOTS*CENTRE_W-1:0];
				endcase
			end
		end
	end

	// command front end
	qmpw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.pop      (pop),
		.q        (q_out)
	);

	// walker back end
	qmpw_walker #(
		.ALIGN_SLOTS (ALIGN_SLOTS)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.version  (version_q),
		.centres  (centres_q),
		.restart  (restart_q),
		.q        (q_out),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// checks
	`QMPW_ASSERT_IMP(a_past_end_origin, m_tvalid && m_tuser, m_tdata[15:0] == 16'd0, "past-end word with nonzero position")
	`QMPW_ASSERT_IMP(a_no_timing, m_tvalid && !m_tuser, (m_tdata[7:0] != TIMING_IDX) && (m_tdata[15:8] != TIMING_IDX), "data word on timing pattern")
	`QMPW_ASSERT_IMP(a_full_has_head, !s_tready, q_out.valid, "queue full without a head entry")
	`QMPW_ASSERT_NXT(a_accept_queued, s_tvalid && s_tready, q_out.valid, "accepted command not queued")

endmodule

[sv/qmpw_front.sv]
// command front end: accepts and decodes items into a short queue
module qmpw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // data_byte
	input  logic                 s_tuser,   // op
	input  logic                 pop,
	output qmpw_pkg::queue_out_t q
);
	import qmpw_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              push;
	logic              do_pop;
	item_t             decoded;

	// decode the incoming item
	always_comb begin
		decoded.op        = op_t'(s_tuser);
		decoded.data_byte = s_tdata;
	end

	assign s_tready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign do_pop   = pop && (count_q != '0);

	assign q.valid = (count_q != '0);
	assign q.item  = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= decoded;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[sv/qmpw_walker.sv]
// walker back end: steps the zigzag one module a cycle unless the output stalls, and emits bit words
module qmpw_walker #(
	parameter int ALIGN_SLOTS = qmpw_pkg::ALIGN_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [qmpw_pkg::VERSION_W-1:0]      version,
	input  logic [ALIGN_SLOTS*qmpw_pkg::CENTRE_W-1:0] centres,
	input  logic                                restart,
	input  qmpw_pkg::queue_out_t                q,
	output logic                                pop,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [qmpw_pkg::TDATA_W-1:0]        m_tdata,   // row, column, bit_value
	output logic                                m_tlast,   // last
	output logic                                m_tuser    // past_end
);
	import qmpw_pkg::*;

	localparam int NW    = $clog2(ALIGN_SLOTS + 1);
	localparam int CNT_W = $clog2(BITS_PER_WORD);
	localparam logic signed [COORD_W:0] ALIGN_HI = (COORD_W+1)'(ALIGN_RADIUS);
	localparam logic signed [COORD_W:0] ALIGN_LO = -ALIGN_HI;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_SEARCH
	} state_t;

	state_t                state_q;
	logic [COORD_W-1:0]    cur_row_q, cur_col_q;
	logic                  up_q, fin_q;
	logic [COORD_W-1:0]    p_row_q, p_col_q;
	logic                  p_up_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [BITS_PER_WORD-1:0] shift_q;
	logic                  out_valid_q;
	logic [COORD_W-1:0]    out_row_q, out_col_q;
	logic                  out_bit_q, out_last_q, out_past_q;

	// geometry
	logic [VERSION_W-1:0]  ver_eff;
	logic [COORD_W-1:0]    dim, dim_m1, dim_m8, dim_m11;
	logic [11:0]           div_prod;
	logic [3:0]            n_raw;
	logic [NW-1:0]         n_align;
	logic                  ver_info;

	// step unit
	logic [COORD_W-1:0]    sc, sr, nc, nr;
	logic                  sup, nup, neg, left_col, edge_hit;
	logic                  term_fin, term, is_dat, func_mod, in_align;
	logic [ALIGN_SLOTS-1:0] rhit, chit;
	logic signed [COORD_W:0] dr [ALIGN_SLOTS];
	logic signed [COORD_W:0] dc [ALIGN_SLOTS];
	logic                  out_free, last_bit, emit_fire;

	// effective version, side length and alignment grid size
	always_comb begin
		if (version < VER_MIN) begin
			ver_eff = VER_MIN;
		end else if (version > VER_MAX) begin
			ver_eff = VER_MAX;
		end else begin
			ver_eff = version;
		end
		dim      = COORD_W'({ver_eff, 2'b00}) + SIDE_BASE;
		dim_m1   = dim - 8'd1;
		dim_m8   = dim - FINDER_EDGE;
		dim_m11  = dim - VERINFO_SPAN;
		div_prod = 12'(ver_eff) * 12'(DIV7_MUL);
		n_raw    = div_prod[11:8] + 4'd2;
		if (ver_eff == VER_MIN) begin
			n_align = '0;
		end else if (n_raw > 4'(ALIGN_SLOTS)) begin
			n_align = NW'(ALIGN_SLOTS);
		end else begin
			n_align = NW'(n_raw);
		end
		ver_info = (ver_eff >= VERINFO_MIN);
	end

	// one zigzag step from the current or candidate module
	always_comb begin
		if (state_q == ST_SEARCH) begin
			sc  = p_col_q;
			sr  = p_row_q;
			sup = p_up_q;
		end else begin
			sc  = cur_col_q;
			sr  = cur_row_q;
			sup = up_q;
		end
		left_col = (sc < TIMING_IDX) != (sc[0] == 1'b0);
		edge_hit = sup ? (sr == '0) : (sr == dim_m1);
		neg = 1'b0;
		nup = sup;
		nr  = sr;
		if (left_col) begin
			nc = sc - 8'd1;
		end else if (edge_hit) begin
			neg = (sc == '0);
			nc  = neg ? '0 : sc - 8'd1;
			nup = !sup;
		end else begin
			nc = sc + 8'd1;
			nr = sup ? sr - 8'd1 : sr + 8'd1;
		end
	end

	// alignment pattern hits per axis
	always_comb begin
		for (int k = 0; k < ALIGN_SLOTS; k++) begin
			dr[k]   = $signed({1'b0, nr}) - $signed({1'b0, centres[k*CENTRE_W +: CENTRE_W]});
			dc[k]   = $signed({1'b0, nc}) - $signed({1'b0, centres[k*CENTRE_W +: CENTRE_W]});
			rhit[k] = (dr[k] >= ALIGN_LO) && (dr[k] <= ALIGN_HI);
			chit[k] = (dc[k] >= ALIGN_LO) && (dc[k] <= ALIGN_HI);
		end
		in_align = 1'b0;
		for (int y = 0; y < ALIGN_SLOTS; y++) begin
			for (int x = 0; x < ALIGN_SLOTS; x++) begin
				if ((NW'(y) < n_align) && (NW'(x) < n_align) && rhit[y] && chit[x] &&
				    !((x == 0 && y == 0) ||
				      (x == 0 && NW'(y) == n_align - NW'(1)) ||
				      (NW'(x) == n_align - NW'(1) && y == 0))) begin
					in_align = 1'b1;
				end
			end
		end
	end

	// function modules and end of walk
	always_comb begin
		func_mod = (nr >= dim) || (nc >= dim) || (nr == TIMING_IDX) || (nc == TIMING_IDX) ||
		           (nc < FINDER_SPAN && nr < FINDER_SPAN) ||
		           (nc >= dim_m8 && nr < FINDER_SPAN) ||
		           (nc < FINDER_SPAN && nr >= dim_m8) ||
		           (ver_info && ((nr < TIMING_IDX && nc >= dim_m11) ||
		                         (nc < TIMING_IDX && nr >= dim_m11)));
		is_dat   = !func_mod && !in_align;
		term_fin = neg || (nc == '0 && nr >= dim_m8);
		term     = term_fin || is_dat;
	end

	assign out_free  = !out_valid_q || m_tready;
	assign last_bit  = (cnt_q == CNT_W'(BITS_PER_WORD - 1));
	assign pop       = (state_q == ST_IDLE) && q.valid && !restart;
	assign emit_fire = (state_q == ST_EMIT) && out_free && !restart;

	// walk sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_row_q   <= RESET_CORNER;
			cur_col_q   <= RESET_CORNER;
			up_q        <= 1'b1;
			fin_q       <= 1'b0;
			p_row_q     <= '0;
			p_col_q     <= '0;
			p_up_q      <= 1'b0;
			cnt_q       <= '0;
			shift_q     <= '0;
			out_valid_q <= 1'b0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			out_bit_q   <= 1'b0;
			out_last_q  <= 1'b0;
			out_past_q  <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (restart) begin
				state_q   <= ST_IDLE;
				cur_row_q <= dim_m1;
				cur_col_q <= dim_m1;
				up_q      <= 1'b1;
				fin_q     <= 1'b0;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (q.valid) begin
							if (q.item.op == OP_RESTART) begin
								cur_row_q <= dim_m1;
								cur_col_q <= dim_m1;
								up_q      <= 1'b1;
								fin_q     <= 1'b0;
							end else begin
								shift_q <= q.item.data_byte;
								cnt_q   <= '0;
								state_q <= ST_EMIT;
							end
						end
					end
					ST_EMIT: begin
						if (out_free) begin
							out_row_q   <= fin_q ? '0 : cur_row_q;
							out_col_q   <= fin_q ? '0 : cur_col_q;
							out_bit_q   <= shift_q[BITS_PER_WORD-1];
							out_last_q  <= last_bit;
							out_past_q  <= fin_q;
							shift_q     <= {shift_q[BITS_PER_WORD-2:0], 1'b0};
							if (fin_q || term) begin
								if (!fin_q) begin
									cur_row_q <= nr;
									cur_col_q <= nc;
									up_q      <= nup;
									fin_q     <= term_fin;
								end
								if (last_bit) begin
									state_q <= ST_IDLE;
								end else begin
									cnt_q <= cnt_q + 1'b1;
								end
							end else begin
								p_row_q <= nr;
								p_col_q <= nc;
								p_up_q  <= nup;
								state_q <= ST_SEARCH;
							end
						end
					end
					ST_SEARCH: begin
						if (term) begin
							cur_row_q <= nr;
							cur_col_q <= nc;
							up_q      <= nup;
							fin_q     <= term_fin;
							if (last_bit) begin
								state_q <= ST_IDLE;
							end else begin
								cnt_q   <= cnt_q + 1'b1;
								state_q <= ST_EMIT;
							end
						end else begin
							p_row_q <= nr;
							p_col_q <= nc;
							p_up_q  <= nup;
						end
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// output word
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W - 2*COORD_W - 1){1'b0}}, out_bit_q, out_col_q, out_row_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_past_q;

endmodule

[verif/qr_module_placement_walker_tb.sv]
// self-checking testbench for the qr data module placement walker
typedef struct packed {
	logic [7:0] row;
	logic [7:0] column;
	logic       bit_value;
	logic       last;
	logic       past_end;
} placed_bit_t;

// tracks the zigzag walk and holds the module words still owed by the block
class walk_tracker;
	localparam int ALIGN_SLOTS   = qmpw_pkg::ALIGN_SLOTS_DEF;
	localparam int TIMING_LINE   = 6;
	localparam int FINDER_SPAN   = 9;
	localparam int FINDER_EDGE   = 8;
	localparam int VERINFO_SPAN  = 11;
	localparam int VERINFO_DEPTH = 6;
	localparam int VERINFO_MIN   = 7;

	logic [5:0]  ver_reg = 6'd1;
	logic [55:0] centres = '0;
	int          walk_col;
	int          walk_row;
	bit          heading_up;
	bit          walk_done;
	placed_bit_t placed_bits[$];
	int          mismatches = 0;

	// out-of-range versions clamp to 1 and 40
	function int eff_ver();
		int v;
		v = int'(ver_reg);
		if (v < 1) v = 1;
		if (v > 40) v = 40;
		return v;
	endfunction

	function int side();
		return 4 * eff_ver() + 17;
	endfunction

	function void restart_walk();
		walk_col   = side() - 1;
		walk_row   = side() - 1;
		heading_up = 1'b1;
		walk_done  = 1'b0;
	endfunction

	function int centre(int k);
		return int'(centres[8*k +: 8]);
	endfunction

	function void write_reg(qmpw_pkg::cfg_idx_t idx, logic [55:0] value);
		if (idx == qmpw_pkg::CFG_VERSION) begin
			ver_reg = value[5:0];
			restart_walk();
		end else begin
			centres = value;
		end
	endfunction

	// step to the next data module, skipping function modules
	function void next_data_module();
		int dim, v, c, r, limit, steps, n, dr, dc;
		bit up, hit;
		dim   = side();
		v     = eff_ver();
		c     = walk_col;
		r     = walk_row;
		up    = heading_up;
		limit = 4 * dim * dim;
		steps = 0;
		n     = (v > 1) ? (v / 7 + 2) : 0;
		if (n > ALIGN_SLOTS) n = ALIGN_SLOTS;
		forever begin
			steps++;
			if (steps > limit || c < 0) begin
				walk_done = 1'b1;
				break;
			end
			// right column of a pair moves left, left column moves back right and along
			if ((c < TIMING_LINE) != ((c & 1) == 0)) begin
				c = c - 1;
			end else begin
				c = c + 1;
				if ((up && r == 0) || (!up && r == dim - 1)) begin
					c  = c - 2;
					up = !up;
				end else begin
					r = up ? r - 1 : r + 1;
				end
			end
			if (c < 0) begin
				walk_done = 1'b1;
				break;
			end
			// column 0 inside the bottom-left finder ends the data area
			if (c == 0 && r >= dim - FINDER_EDGE) begin
				walk_done = 1'b1;
				break;
			end
			hit = 1'b1;
			if (r < 0 || c < 0 || r >= dim || c >= dim) hit = 1'b0;
			else if (r == TIMING_LINE || c == TIMING_LINE) hit = 1'b0;
			else if (c < FINDER_SPAN && r < FINDER_SPAN) hit = 1'b0;
			else if (c >= dim - FINDER_EDGE && r < FINDER_SPAN) hit = 1'b0;
			else if (c < FINDER_SPAN && r >= dim - FINDER_EDGE) hit = 1'b0;
			else if (v >= VERINFO_MIN && r < VERINFO_DEPTH && c >= dim - VERINFO_SPAN) hit = 1'b0;
			else if (v >= VERINFO_MIN && c < VERINFO_DEPTH && r >= dim - VERINFO_SPAN) hit = 1'b0;
			else begin
				// alignment blocks, minus the three finder corners of the grid
				for (int y = 0; y < n; y++) begin
					dr = r - centre(y);
					if (dr < -2 || dr > 2) continue;
					for (int x = 0; x < n; x++) begin
						if ((x == 0 && y == 0) || (x == 0 && y == n - 1) ||
						    (x == n - 1 && y == 0)) continue;
						dc = c - centre(x);
						if (dc >= -2 && dc <= 2) hit = 1'b0;
					end
				end
			end
			if (hit) break;
		end
		if (c < 0) c = 0;
		if (r < 0) r = 0;
		walk_col   = c & 'hFF;
		walk_row   = r & 'hFF;
		heading_up = up;
	endfunction

	// accepted command: a restart moves the walk, a place owes eight words
	function void note_command(qmpw_pkg::op_t op, logic [7:0] data_byte);
		placed_bit_t w;
		if (op == qmpw_pkg::OP_RESTART) begin
			restart_walk();
			return;
		end
		for (int i = 0; i < 8; i++) begin
			w.bit_value = data_byte[7-i];
			w.last      = (i == 7);
			if (walk_done) begin
				w.row      = '0;
				w.column   = '0;
				w.past_end = 1'b1;
			end else begin
				w.row      = walk_row[7:0];
				w.column   = walk_col[7:0];
				w.past_end = 1'b0;
				next_data_module();
			end
			placed_bits.push_back(w);
		end
	endfunction

	// compare an output word with the oldest owed one
	function void check_word(placed_bit_t got);
		placed_bit_t want;
		if (placed_bits.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: row %0d col %0d bit %0d last %0d past_end %0d",
					got.row, got.column, got.bit_value, got.last, got.past_end);
			return;
		end
		want = placed_bits.pop_front();
		if (got.row !== want.row || got.column !== want.column ||
		    got.bit_value !== want.bit_value || got.last !== want.last ||
		    got.past_end !== want.past_end) begin
			mismatches++;
			if (mismatches <= 10)
				$display("word mismatch: want row %0d col %0d bit %0d last %0d pe %0d, got row %0d col %0d bit %0d last %0d pe %0d",
					want.row, want.column, want.bit_value, want.last, want.past_end,
					got.row, got.column, got.bit_value, got.last, got.past_end);
		end
	endfunction

	function int pending();
		return placed_bits.size();
	endfunction
endclass

module qr_module_placement_walker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qmpw_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          cycle_count = 0;
	walk_tracker tracker;

	qr_module_placement_walker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// output word monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_word(placed_bit_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[16],
				m_tlast, m_tuser}));
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[qr_module_placement_walker] ERROR");
			$finish;
		end
	end

	// one command word; tvalid stays high into the next command
	task automatic send_cmd(op_t op, logic [7:0] data_byte);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data_byte;
		do @(posedge clk); while (!s_tready);
		tracker.note_command(op, data_byte);
	endtask

	// wait until every owed word is out, then let a trailing restart settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers in random order
	task automatic set_config(int ver, logic [55:0] centres);
		logic [55:0] word;
		cfg_idx_t idx;
		bit align_first;
		align_first = 1'($urandom_range(1));
		for (int k = 0; k < 2; k++) begin
			if ((k == 0) == align_first) begin
				idx  = CFG_ALIGN;
				word = centres;
			end else begin
				idx  = CFG_VERSION;
				word = {50'({$urandom, $urandom}), 6'(ver)};
			end
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= word;
			do @(posedge clk); while (!cfg_ready);
			tracker.write_reg(idx, word);
		end
		cfg_valid <= 1'b0;
	endtask

	// alignment grid as a symbol of this version lays it out; unused slots random
	function automatic logic [55:0] standard_centres(int ver);
		logic [55:0] c;
		int v, dim, n;
		c   = 56'({$urandom, $urandom});
		v   = (ver < 1) ? 1 : (ver > 40) ? 40 : ver;
		dim = 4 * v + 17;
		n   = (v > 1) ? (v / 7 + 2) : 0;
		if (n > ALIGN_SLOTS_DEF) n = ALIGN_SLOTS_DEF;
		for (int k = 0; k < n; k++)
			c[8*k +: 8] = 8'((k == n - 1) ? dim - 7 : 6 + k * ((dim - 13) / (n - 1)));
		return c;
	endfunction

	// one random phase: idle, configure, then a stream of mostly place commands
	task automatic run_phase(int ver, logic [55:0] centres, int count, int restart_pct,
			int idle_mode);
		wait_idle();
		case (idle_mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
			default: begin send_idle_pct = 12; recv_stall_pct = 12; end
		endcase
		set_config(ver, centres);
		repeat (count) begin
			if ($urandom_range(99) < restart_pct)
				send_cmd(OP_RESTART, 8'($urandom_range(255)));
			else
				send_cmd(OP_PLACE, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		logic [55:0] edge_grid;
		int dim;
		tracker = new();
		tracker.restart_walk();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: data extremes and restarts at the reset configuration
		send_cmd(OP_PLACE, 8'h00);
		send_cmd(OP_PLACE, 8'hFF);
		send_cmd(OP_PLACE, 8'h80);
		send_cmd(OP_PLACE, 8'h01);
		send_cmd(OP_RESTART, 8'hFF);
		send_cmd(OP_PLACE, 8'h7F);
		send_cmd(OP_PLACE, 8'hFE);
		send_cmd(OP_RESTART, 8'h00);
		send_cmd(OP_PLACE, 8'hAA);
		send_cmd(OP_PLACE, 8'h55);

		// version above range clamps to 40, centres all off the symbol
		wait_idle();
		set_config(63, {56{1'b1}});
		send_cmd(OP_PLACE, 8'hC3);
		send_cmd(OP_PLACE, 8'h3C);

		// first version with version-info blocks
		wait_idle();
		set_config(7, standard_centres(7));
		send_cmd(OP_PLACE, 8'h0F);
		send_cmd(OP_PLACE, 8'hF0);
		send_cmd(OP_PLACE, 8'h99);
		send_cmd(OP_PLACE, 8'h66);

		// version zero clamps to 1, centres all zero
		wait_idle();
		set_config(0, '0);
		send_cmd(OP_PLACE, 8'h12);
		send_cmd(OP_PLACE, 8'h34);
		send_cmd(OP_PLACE, 8'h56);
		send_cmd(OP_RESTART, 8'hA5);
		send_cmd(OP_PLACE, 8'h78);
		send_cmd(OP_PLACE, 8'h9A);

		// random phases; small versions run past the end of the data area
		run_phase(1, '0, 35, 0, 0);
		run_phase(2, standard_centres(2), 48, 0, 1);
		run_phase(7, standard_centres(7), 20, 10, 2);
		run_phase(40, standard_centres(40), 20, 10, 3);
		run_phase(41, 56'({$urandom, $urandom}), 15, 10, 0);
		run_phase($urandom_range(40, 1), 56'({$urandom, $urandom}), 20, 10, 1);

		// centres on and just past the symbol edges
		dim = 4 * 14 + 17;
		edge_grid = 56'({$urandom, $urandom});
		edge_grid[7:0]   = 8'(dim + 1);
		edge_grid[15:8]  = 8'(dim - 1);
		edge_grid[23:16] = 8'd0;
		edge_grid[31:24] = 8'(dim);
		edge_grid[39:32] = 8'd1;
		run_phase(14, edge_grid, 15, 5, 2);

		run_phase(1, 56'({$urandom, $urandom}), 20, 3, 3);
		run_phase(0, {56{1'b1}}, 20, 0, 0);

		wait_idle();
		if (tracker.mismatches == 0)
			$display("[qr_module_placement_walker] OK");
		else
			$display("[qr_module_placement_walker] ERROR");
		$finish;
	end
endmodule
